[hdl/iqm_pkg.sv]
`timescale 1ns / 1ps

package iqm_pkg;

  // Channel count and field widths
  localparam int NumChannels = 4;
  localparam int SampleW     = 16;
  localparam int AbsW        = SampleW + 1;
  localparam int SquareW     = 2 * SampleW - 1;
  localparam int SqW         = 2 * SampleW;
  localparam int MagW        = 16;
  localparam int PeakW       = $clog2(NumChannels);

  // Pipeline depths: abs, square, sum, one stage per root bit, select, peak
  localparam int SqrtStages = MagW;
  localparam int LaneLat    = 3 + SqrtStages + 1;
  localparam int TotalLat   = LaneLat + 1;

  // Method register codes
  typedef enum logic {
    METHOD_ESTIMATE = 1'b0,
    METHOD_EXACT    = 1'b1
  } method_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [AbsW-1:0]           abs_t;
  typedef logic [SquareW-1:0]        square_t;
  typedef logic [SqW-1:0]            sq_t;
  typedef logic [SqW:0]              delta_t;
  typedef logic [MagW-1:0]           mag_t;
  typedef logic [PeakW-1:0]          peak_t;

endpackage

[hdl/iqm_isqrt.sv]
`timescale 1ns / 1ps

// Pipelined restoring square root, one root bit per stage
module iqm_isqrt (
  input  logic          clk_i,
  input  logic          en_i,
  input  iqm_pkg::sq_t  s_i,
  output iqm_pkg::mag_t root_o,
  output iqm_pkg::sq_t  rem_o
);
  import iqm_pkg::*;

  sq_t  rem_q  [SqrtStages];
  mag_t root_q [SqrtStages];

  for (genvar j = 0; j < SqrtStages; j++) begin : g_stage
    localparam int K = SqrtStages - 1 - j;
    sq_t    rem_in;
    mag_t   root_in;
    delta_t delta;
    logic   take;

    if (j == 0) begin : g_first
      assign rem_in  = s_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (root + 2^K)^2 - root^2 = root*2^(K+1) + 2^(2K)
    assign delta = (delta_t'(root_in) << (K + 1)) + (delta_t'(1) << (2 * K));
    assign take  = {1'b0, rem_in} >= delta;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? (rem_in - delta[SqW-1:0]) : rem_in;
        root_q[j] <= take ? (root_in | (mag_t'(1) << K)) : root_in;
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];
  assign rem_o  = rem_q[SqrtStages-1];

endmodule

[hdl/iqm_lane.sv]
`timescale 1ns / 1ps

// One channel: abs, estimate and exact magnitude, method select
module iqm_lane (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             method_i,
  input  iqm_pkg::sample_t i_i,
  input  iqm_pkg::sample_t q_i,
  output iqm_pkg::mag_t    mag_o
);
  import iqm_pkg::*;

  function automatic abs_t abs_val(sample_t v);
    abs_t r;
    if (v[SampleW-1]) begin
      r = abs_t'({1'b0, ~v}) + abs_t'(1);
    end else begin
      r = abs_t'({1'b0, v});
    end
    return r;
  endfunction

  abs_t               ai_q, aq_q;
  square_t            sqi_q, sqq_q;
  sq_t                sum_q;
  mag_t               est_s2_q, est_s3_q;
  mag_t               est_dly_q [SqrtStages];
  mag_t               mag_q;
  logic [2*AbsW-1:0]  prod_i, prod_q;
  abs_t               hi, lo;
  abs_t               est_full;
  mag_t               root;
  sq_t                rem;
  logic               round_up;
  mag_t               exact;

  // Stage 1: absolute values, -32768 maps to 32768
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ai_q <= abs_val(i_i);
      aq_q <= abs_val(q_i);
    end
  end

  // Stage 2: squares and max plus half min
  assign prod_i   = ai_q * ai_q;
  assign prod_q   = aq_q * aq_q;
  assign hi       = (ai_q > aq_q) ? ai_q : aq_q;
  assign lo       = (ai_q > aq_q) ? aq_q : ai_q;
  assign est_full = hi + (lo >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqi_q    <= prod_i[SquareW-1:0];
      sqq_q    <= prod_q[SquareW-1:0];
      est_s2_q <= est_full[MagW-1:0];
    end
  end

  // Stage 3: sum of squares, at most 2^31
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= sq_t'(sqi_q) + sq_t'(sqq_q);
      est_s3_q <= est_s2_q;
    end
  end

  iqm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .s_i    (sum_q),
    .root_o (root),
    .rem_o  (rem)
  );

  // Estimate rides along with the root pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      est_dly_q[0] <= est_s3_q;
      for (int k = 1; k < SqrtStages; k++) begin
        est_dly_q[k] <= est_dly_q[k-1];
      end
    end
  end

  // Round to nearest: remainder above root means s > r*r + r
  assign round_up = rem > sq_t'(root);
  assign exact    = root + mag_t'(round_up);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= (method_i == METHOD_EXACT) ? exact : est_dly_q[SqrtStages-1];
    end
  end

  assign mag_o = mag_q;

endmodule

[hdl/iqm_peak.sv]
`timescale 1ns / 1ps

// Merge stage: register magnitudes and pick the strongest channel
module iqm_peak (
  input  logic           clk_i,
  input  logic           en_i,
  input  iqm_pkg::mag_t  mag_i [iqm_pkg::NumChannels],
  output iqm_pkg::mag_t  mag_o [iqm_pkg::NumChannels],
  output iqm_pkg::peak_t peak_o
);
  import iqm_pkg::*;

  mag_t  mag_q [NumChannels];
  peak_t peak_q;
  mag_t  best;
  peak_t best_idx;

  // Strictly greater wins, so ties keep the lower index
  always_comb begin
    best     = mag_i[0];
    best_idx = '0;
    for (int k = 1; k < NumChannels; k++) begin
      if (mag_i[k] > best) begin
        best     = mag_i[k];
        best_idx = peak_t'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_i;
      peak_q <= best_idx;
    end
  end

  assign mag_o  = mag_q;
  assign peak_o = peak_q;

endmodule

[hdl/iq_magnitude_peak_detect_top.sv]
`timescale 1ns / 1ps

// Four-channel I/Q magnitude and peak finder. Each input word carries a signed
// 16-bit I and Q for channels 0..3; each output word carries the four
// magnitudes and the lowest index of the strictly largest one (0 if all are
// zero). Method register 0 gives max(|I|,|Q|) + min(|I|,|Q|)/2, 1 gives
// sqrt(I^2+Q^2) rounded to nearest. One word is taken per clock unless
// stalled; words pass the 16-stage square-root pipeline in each of the four
// lanes plus the abs, square, sum, select and peak registers. A stalled output
// freezes the whole pipeline, so input stall follows output stall while a word
// waits. Write the method register only while no word is in flight.
module iq_magnitude_peak_detect_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  iqm_pkg::sample_t     i_ch0_i,
  input  iqm_pkg::sample_t     q_ch0_i,
  input  iqm_pkg::sample_t     i_ch1_i,
  input  iqm_pkg::sample_t     q_ch1_i,
  input  iqm_pkg::sample_t     i_ch2_i,
  input  iqm_pkg::sample_t     q_ch2_i,
  input  iqm_pkg::sample_t     i_ch3_i,
  input  iqm_pkg::sample_t     q_ch3_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output iqm_pkg::mag_t        mag_ch0_o,
  output iqm_pkg::mag_t        mag_ch1_o,
  output iqm_pkg::mag_t        mag_ch2_o,
  output iqm_pkg::mag_t        mag_ch3_o,
  output iqm_pkg::peak_t       peak_channel_o
);
  import iqm_pkg::*;

  logic                method_q;
  logic [TotalLat-1:0] vld_q;
  logic                adv;
  sample_t             i_arr [NumChannels];
  sample_t             q_arr [NumChannels];
  mag_t                lane_mag [NumChannels];
  mag_t                mag_out [NumChannels];
  peak_t               peak;

  // Method register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_ESTIMATE;
    end else if (cfg_we_i) begin
      method_q <= cfg_wdata_i;
    end
  end

  // Pipeline moves unless a finished word is held by the sink
  assign adv        = !vld_q[TotalLat-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TotalLat-2:0], in_valid_i};
    end
  end

  assign i_arr[0] = i_ch0_i;
  assign q_arr[0] = q_ch0_i;
  assign i_arr[1] = i_ch1_i;
  assign q_arr[1] = q_ch1_i;
  assign i_arr[2] = i_ch2_i;
  assign q_arr[2] = q_ch2_i;
  assign i_arr[3] = i_ch3_i;
  assign q_arr[3] = q_ch3_i;

  // Lanes
  for (genvar c = 0; c < NumChannels; c++) begin : g_lane
    iqm_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .method_i (method_q),
      .i_i      (i_arr[c]),
      .q_i      (q_arr[c]),
      .mag_o    (lane_mag[c])
    );
  end

  iqm_peak u_peak (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mag_i  (lane_mag),
    .mag_o  (mag_out),
    .peak_o (peak)
  );

  assign out_valid_o    = vld_q[TotalLat-1];
  assign mag_ch0_o      = mag_out[0];
  assign mag_ch1_o      = mag_out[1];
  assign mag_ch2_o      = mag_out[2];
  assign mag_ch3_o      = mag_out[3];
  assign peak_channel_o = peak;

`ifndef NO_ASSERTIONS
  // Peak channel is at least as large as every channel
  a_peak_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mag_out[peak] >= mag_out[0] && mag_out[peak] >= mag_out[1] &&
                     mag_out[peak] >= mag_out[2] && mag_out[peak] >= mag_out[3]))
    else $error("peak channel is not the largest magnitude");

  // Channels below the peak are strictly smaller
  a_peak_lowest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((peak == 2'd0 || mag_out[0] < mag_out[peak]) &&
                     (peak == 2'd0 || peak == 2'd1 || mag_out[1] < mag_out[peak]) &&
                     (peak != 2'd3 || mag_out[2] < mag_out[peak])))
    else $error("peak channel is not the lowest strict maximum");

  // An accepted word enters the valid pipeline
  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word lost from valid pipeline");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import iqm_pkg::*;

  localparam int IdlePct    = 11;
  localparam int LongHold   = 300;
  localparam int RandomSets = 100;
  localparam int CycleLimit = 200000;

  // One input word: I and Q of every channel
  typedef struct packed {
    logic [NumChannels-1:0][SampleW-1:0] i_s;
    logic [NumChannels-1:0][SampleW-1:0] q_s;
  } iq_set_t;

  // One output word: four magnitudes and the peak index
  typedef struct packed {
    logic [NumChannels-1:0][MagW-1:0] mag;
    peak_t                            peak;
  } mag_peak_t;

  // Hand-picked sets: I0, Q0, I1, Q1, I2, Q2, I3, Q3
  localparam int DirectedSets [12][8] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
    '{-32768, 0, 0, -32768, 32767, 0, 0, 32767},
    '{0, 0, 0, 0, 0, 0, 5, -7},
    '{1, 1, 2, 2, 100, -200, 3, 3},
    '{0, 1, 300, 400, 10, 10, 400, 300},
    '{-1, -32768, 32767, -1, -2, 3, 3, -2},
    '{1, 1, 1, -1, -3, 1, 2, 3},
    '{1, 1, 1, 2, 2, 2, 3, 3},
    '{-32768, 32767, 32767, -32768, -32767, -32767, 12345, -23456},
    '{-20000, 15000, 7, 7, -9, 4, 0, 1}
  };

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    cfg_we_i    = 1'b0;
  logic    cfg_wdata_i = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    out_stall_i = 1'b0;
  logic    in_stall_o;
  logic    out_valid_o;
  mag_t    mag_ch0_o, mag_ch1_o, mag_ch2_o, mag_ch3_o;
  peak_t   peak_channel_o;
  iq_set_t cur_set     = '0;

  iq_set_t   iq_sets_pending [$];
  mag_peak_t mag_peak_due [$];
  method_e   method_r    = METHOD_ESTIMATE;
  bit        no_idle     = 1'b0;
  int        hold_reqs   = 0;
  int        hold_served = 0;
  int        hold_left   = 0;
  int        mismatches  = 0;
  int        cycles      = 0;

  iq_magnitude_peak_detect_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .i_ch0_i        (sample_t'(cur_set.i_s[0])),
    .q_ch0_i        (sample_t'(cur_set.q_s[0])),
    .i_ch1_i        (sample_t'(cur_set.i_s[1])),
    .q_ch1_i        (sample_t'(cur_set.q_s[1])),
    .i_ch2_i        (sample_t'(cur_set.i_s[2])),
    .q_ch2_i        (sample_t'(cur_set.q_s[2])),
    .i_ch3_i        (sample_t'(cur_set.i_s[3])),
    .q_ch3_i        (sample_t'(cur_set.q_s[3])),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mag_ch0_o      (mag_ch0_o),
    .mag_ch1_o      (mag_ch1_o),
    .mag_ch2_o      (mag_ch2_o),
    .mag_ch3_o      (mag_ch3_o),
    .peak_channel_o (peak_channel_o)
  );

  always #5 clk_i = ~clk_i;

  // Expected magnitudes and peak for one set under the given method
  function automatic mag_peak_t mag_peak_of(iq_set_t set, method_e m);
    mag_peak_t res;
    sample_t   iv, qv;
    abs_t      ai, aq, hi, lo;
    longint    s, r;
    mag_t      best;
    res  = '0;
    best = '0;
    for (int ch = 0; ch < NumChannels; ch++) begin
      iv = sample_t'(set.i_s[ch]);
      qv = sample_t'(set.q_s[ch]);
      ai = abs_t'(iv < 0 ? -longint'(iv) : longint'(iv));
      aq = abs_t'(qv < 0 ? -longint'(qv) : longint'(qv));
      hi = (ai > aq) ? ai : aq;
      lo = (ai > aq) ? aq : ai;
      if (m == METHOD_ESTIMATE) begin
        res.mag[ch] = mag_t'(hi + (lo >> 1));
      end else begin
        // bitwise floor root, then round up past the midpoint
        s = longint'(ai) * longint'(ai) + longint'(aq) * longint'(aq);
        r = 0;
        for (int b = MagW - 1; b >= 0; b--) begin
          if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= s) begin
            r = r | (longint'(1) << b);
          end
        end
        if (s > r * r + r) r = r + 1;
        res.mag[ch] = mag_t'(r);
      end
      // strict compare: ties keep the lower channel
      if (res.mag[ch] > best) begin
        best     = res.mag[ch];
        res.peak = peak_t'(ch);
      end
    end
    return res;
  endfunction

  // Sample biased toward the extremes and small values
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7fff);
      2:       return sample_t'(int'($urandom_range(0, 8)) - 4);
      3:       return sample_t'(int'($urandom_range(0, 2047)) - 1024);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic iq_set_t rand_set();
    iq_set_t set;
    int      src;
    for (int ch = 0; ch < NumChannels; ch++) begin
      set.i_s[ch] = rand_sample();
      set.q_s[ch] = rand_sample();
      // now and then rotate an earlier channel by 90 degrees to force a tie
      if (ch > 0 && $urandom_range(0, 5) == 0) begin
        src         = $urandom_range(0, ch - 1);
        set.i_s[ch] = set.q_s[src];
        set.q_s[ch] = -set.i_s[src];
      end
    end
    return set;
  endfunction

  // Driver: offer queued words, hold while stalled, idle at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        mag_peak_due.push_back(mag_peak_of(cur_set, method_r));
      end
      if (in_valid_i && in_stall_o) begin
        // payload held
      end else if (iq_sets_pending.size() != 0 &&
                   (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
        cur_set    <= iq_sets_pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk_i) begin
    mag_peak_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.mag[0] = mag_ch0_o;
        got.mag[1] = mag_ch1_o;
        got.mag[2] = mag_ch2_o;
        got.mag[3] = mag_ch3_o;
        got.peak   = peak_channel_o;
        if (mag_peak_due.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word: expected none, got mags %0d %0d %0d %0d peak %0d",
                   $time, got.mag[0], got.mag[1], got.mag[2], got.mag[3], got.peak);
        end else begin
          want = mag_peak_due.pop_front();
          for (int ch = 0; ch < NumChannels; ch++) begin
            if (got.mag[ch] !== want.mag[ch]) begin
              mismatches++;
              $display("%0t mag_ch%0d: expected %0d, got %0d",
                       $time, ch, want.mag[ch], got.mag[ch]);
            end
          end
          if (got.peak !== want.peak) begin
            mismatches++;
            $display("%0t peak_channel: expected %0d, got %0d", $time, want.peak, got.peak);
          end
        end
      end
      // long hold on request, else random stall
      if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** iq_magnitude_peak_detect_top: FAILED **");
      $finish;
    end
  end

  // Wait until no word is queued, offered or in flight
  task automatic wait_drained();
    do @(negedge clk_i);
    while (iq_sets_pending.size() != 0 || in_valid_i || mag_peak_due.size() != 0);
  endtask

  task automatic write_method(method_e m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    method_r    = m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Sequence: directed sets under both methods, then random phases
  initial begin
    iq_set_t set;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int pass = 0; pass < 2; pass++) begin
      write_method(pass == 0 ? METHOD_ESTIMATE : METHOD_EXACT);
      for (int k = 0; k < 12; k++) begin
        for (int ch = 0; ch < NumChannels; ch++) begin
          set.i_s[ch] = sample_t'(DirectedSets[k][2 * ch]);
          set.q_s[ch] = sample_t'(DirectedSets[k][2 * ch + 1]);
        end
        iq_sets_pending.push_back(set);
      end
      wait_drained();
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_method(phase % 2 == 0 ? METHOD_EXACT : METHOD_ESTIMATE);
      no_idle = (phase == 1);
      for (int k = 0; k < RandomSets; k++) iq_sets_pending.push_back(rand_set());
      // back up the pipe until the input stalls
      if (phase == 0) hold_reqs++;
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (TotalLat + 5) @(posedge clk_i);
    if (mismatches == 0 && mag_peak_due.size() == 0) begin
      $display("** iq_magnitude_peak_detect_top: PASSED **");
    end else begin
      $display("** iq_magnitude_peak_detect_top: FAILED **");
    end
    $finish;
  end

endmodule
